>>> hdl/hrlc_pkg.sv
// Shared types, constants and keyword tables for the request line classifier.
`default_nettype none
package hrlc_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int OUT_W           = 32;
    localparam int IDX_W           = 4;
    localparam int CLS_W           = 3;
    localparam int POS_W           = 4;
    localparam int MASK_W          = 5;

    localparam int NUM_METH_CLS  = 5;
    localparam int NUM_URI_CLS   = 6;
    localparam int M_AW          = $clog2(NUM_METH_CLS);
    localparam int U_AW          = $clog2(NUM_URI_CLS);
    localparam int URI_IDX_BASE  = NUM_METH_CLS;
    localparam int READ_IDX_LAST = NUM_METH_CLS + NUM_URI_CLS - 1;

    localparam logic [CLS_W-1:0] METH_UNKNOWN = 3'd4;
    localparam logic [CLS_W-1:0] URI_UNKNOWN  = 3'd5;
    localparam logic [POS_W-1:0] POS_MAX      = 4'd15;
    localparam logic [7:0]       CHAR_SPACE   = 8'h20;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_READ  = 1'b1;
    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        TOK_METHOD = 2'd0,
        TOK_URI    = 2'd1,
        TOK_PROTO  = 2'd2,
        TOK_DONE   = 2'd3
    } t_tok;

    typedef enum logic [1:0] {
        RSEL_NONE = 2'd0,
        RSEL_METH = 2'd1,
        RSEL_URI  = 2'd2
    } t_rsel;

    typedef struct packed {
        logic [CLS_W-1:0] method;
        logic [CLS_W-1:0] uri;
        logic             proto;
    } t_line_cls;

    localparam logic [7:0] METHOD_TXT [4][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00}
    };
    localparam logic [POS_W-1:0] METHOD_LEN [4] = '{4'd3, 4'd4, 4'd3, 4'd6};

    localparam logic [7:0] URI_TXT [5][8] = '{
        '{"/", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"/", "o", "r", "d", "e", "r", 8'h00, 8'h00},
        '{"/", "p", "r", "o", "d", "u", "c", "t"},
        '{"/", "b", "a", "s", "k", "e", "t", 8'h00},
        '{"/", "h", "e", "l", "p", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [POS_W-1:0] URI_LEN [5] = '{4'd1, 4'd6, 4'd8, 4'd7, 4'd5};

    localparam logic [7:0] PROTO_TXT [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};
    localparam logic [POS_W-1:0] PROTO_LEN = 4'd8;

    // Keywords that still agree with byte b at position pos; 1 = keep.
    function automatic logic [MASK_W-1:0] match_keep(input t_tok tok,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [7:0] b);
        logic [MASK_W-1:0] keep;
        keep = '1;
        case (tok)
            TOK_METHOD: begin
                for (int i = 0; i < 4; i++) begin
                    keep[i] = (pos < METHOD_LEN[i]) && (METHOD_TXT[i][pos[2:0]] == b);
                end
            end
            TOK_URI: begin
                for (int i = 0; i < 5; i++) begin
                    keep[i] = (pos < URI_LEN[i]) && (URI_TXT[i][pos[2:0]] == b);
                end
            end
            TOK_PROTO: begin
                keep[0] = (pos < PROTO_LEN) && (PROTO_TXT[pos[2:0]] == b);
            end
            default: keep = '1;
        endcase
        return keep;
    endfunction

    function automatic logic [CLS_W-1:0] pick_method(input logic [MASK_W-1:0] mask,
                                                     input logic [POS_W-1:0] pos);
        logic [CLS_W-1:0] res;
        res = METH_UNKNOWN;
        for (int i = 3; i >= 0; i--) begin
            if (mask[i] && (METHOD_LEN[i] == pos)) res = CLS_W'(i);
        end
        return res;
    endfunction

    function automatic logic [CLS_W-1:0] pick_uri(input logic [MASK_W-1:0] mask,
                                                  input logic [POS_W-1:0] pos);
        logic [CLS_W-1:0] res;
        res = URI_UNKNOWN;
        for (int i = 4; i >= 0; i--) begin
            if (mask[i] && (URI_LEN[i] == pos)) res = CLS_W'(i);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hdl/hrlc_if.sv
// Request and response channel interfaces for the request line classifier.
`default_nettype none
interface hrlc_req_if;
    import hrlc_pkg::*;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [7:0]       data_byte;
    logic             end_of_line;
    logic [IDX_W-1:0] counter_index;

    modport source (output valid, cmd, data_byte, end_of_line, counter_index,
                    input ready);
    modport sink   (input valid, cmd, data_byte, end_of_line, counter_index,
                    output ready);
endinterface

interface hrlc_rsp_if;
    import hrlc_pkg::*;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [CLS_W-1:0] method_class;
    logic [CLS_W-1:0] uri_class;
    logic             protocol_known;
    logic [OUT_W-1:0] method_count;
    logic [OUT_W-1:0] uri_count;
    logic [OUT_W-1:0] read_value;

    modport source (output valid, kind, method_class, uri_class, protocol_known,
                    method_count, uri_count, read_value, input ready);
    modport sink   (input valid, kind, method_class, uri_class, protocol_known,
                    method_count, uri_count, read_value, output ready);
endinterface
`default_nettype wire

>>> hdl/hrlc_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module hrlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/hrlc_parse.sv
// Request line tokeniser and keyword matcher, one byte per cycle while i_step is high.
`default_nettype none
module hrlc_parse (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire logic [7:0]               i_byte,
    input  wire logic                     i_eol,
    output      hrlc_pkg::t_line_cls      o_cls
);
    import hrlc_pkg::*;

    t_tok              r_tok,   n_tok;
    logic              r_skip,  n_skip;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [MASK_W-1:0] r_mask,  n_mask;
    logic [CLS_W-1:0]  r_meth,  n_meth;
    logic [CLS_W-1:0]  r_uri,   n_uri;
    logic              r_proto, n_proto;

    // State after this byte, before the line end is applied
    t_tok              a_tok;
    logic              a_skip;
    logic [POS_W-1:0]  a_pos;
    logic [MASK_W-1:0] a_mask;
    logic [CLS_W-1:0]  a_meth, a_uri;
    logic              a_proto;

    always_comb begin
        a_tok   = r_tok;
        a_skip  = r_skip;
        a_pos   = r_pos;
        a_mask  = r_mask;
        a_meth  = r_meth;
        a_uri   = r_uri;
        a_proto = r_proto;
        if (r_tok != TOK_DONE) begin
            if (i_byte == CHAR_SPACE) begin
                if (!r_skip) begin
                    unique case (r_tok)
                        TOK_METHOD: begin
                            a_meth = pick_method(r_mask, r_pos);
                            a_tok  = TOK_URI;
                        end
                        TOK_URI: begin
                            a_uri = pick_uri(r_mask, r_pos);
                            a_tok = TOK_PROTO;
                        end
                        TOK_PROTO: begin
                            a_proto = r_mask[0] && (r_pos == PROTO_LEN);
                            a_tok   = TOK_DONE;
                        end
                        default: a_tok = TOK_DONE;
                    endcase
                    a_skip = 1'b1;
                    a_pos  = '0;
                    a_mask = '1;
                end
            end else begin
                a_skip = 1'b0;
                a_mask = r_mask & match_keep(r_tok, r_pos, i_byte);
                a_pos  = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
            end
        end
    end

    // Close the open token at the line end
    always_comb begin
        o_cls.method = a_meth;
        o_cls.uri    = a_uri;
        o_cls.proto  = a_proto;
        unique case (a_tok)
            TOK_METHOD: o_cls.method = pick_method(a_mask, a_pos);
            TOK_URI:    o_cls.uri    = pick_uri(a_mask, a_pos);
            TOK_PROTO:  o_cls.proto  = a_mask[0] && (a_pos == PROTO_LEN);
            default:    ;
        endcase
    end

    always_comb begin
        n_tok   = r_tok;
        n_skip  = r_skip;
        n_pos   = r_pos;
        n_mask  = r_mask;
        n_meth  = r_meth;
        n_uri   = r_uri;
        n_proto = r_proto;
        if (i_step) begin
            if (i_eol) begin
                n_tok   = TOK_METHOD;
                n_skip  = 1'b1;
                n_pos   = '0;
                n_mask  = '1;
                n_meth  = METH_UNKNOWN;
                n_uri   = URI_UNKNOWN;
                n_proto = 1'b0;
            end else begin
                n_tok   = a_tok;
                n_skip  = a_skip;
                n_pos   = a_pos;
                n_mask  = a_mask;
                n_meth  = a_meth;
                n_uri   = a_uri;
                n_proto = a_proto;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= TOK_METHOD;
            r_skip  <= 1'b1;
            r_pos   <= '0;
            r_mask  <= '1;
            r_meth  <= METH_UNKNOWN;
            r_uri   <= URI_UNKNOWN;
            r_proto <= 1'b0;
        end else begin
            r_tok   <= n_tok;
            r_skip  <= n_skip;
            r_pos   <= n_pos;
            r_mask  <= n_mask;
            r_meth  <= n_meth;
            r_uri   <= n_uri;
            r_proto <= n_proto;
        end
    end
endmodule
`default_nettype wire

>>> hdl/http_request_line_classifier_stats.sv
// Request line classifier top level: parser, counter RAMs and response register.
// A result is registered in stage 1 and then in the output register before it leaves.
// Throughput: one transfer per cycle unless the output stalls; the counter RAM read is issued in the accept cycle and
// the saturating increment is written back when stage 1 fires, bypassed to a following line.
// Reset clears the parser state and the per-entry counter valid bits, so counters read zero.
// No clearing pass is needed; the block accepts transfers in the first cycle after reset.
`default_nettype none
module http_request_line_classifier_stats #(
    parameter int COUNT_WIDTH = hrlc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hrlc_req_if.sink   i_req,
    hrlc_rsp_if.source o_rsp
);
    import hrlc_pkg::*;

    logic      acc, is_read, step, s1_adv, s1_fire;
    t_line_cls line_cls;
    t_rsel     rsel;
    logic [IDX_W-1:0] idx_off;
    logic [M_AW-1:0]  m_addr0, m_raddr;
    logic [U_AW-1:0]  u_addr0, u_raddr;
    logic [COUNT_WIDTH-1:0] m_q, u_q, m_old, u_old, m_new, u_new;
    logic [COUNT_WIDTH+OUT_W-1:0] ext_m_new, ext_u_new, ext_m_old, ext_u_old;
    logic m_we, u_we;

    // Stage 1: RAM read outstanding
    logic            r_s1_valid;
    logic            r_s1_kind;
    t_rsel           r_s1_sel;
    logic [M_AW-1:0] r_s1_m;
    logic [U_AW-1:0] r_s1_u;
    logic            r_s1_proto;

    // Last write-back, for bypass into the following read
    logic                   r_fw_m_vld, r_fw_u_vld;
    logic [M_AW-1:0]        r_fw_m_addr;
    logic [U_AW-1:0]        r_fw_u_addr;
    logic [COUNT_WIDTH-1:0] r_fw_m_data, r_fw_u_data;

    logic [NUM_METH_CLS-1:0] r_m_vld;
    logic [NUM_URI_CLS-1:0]  r_u_vld;

    logic r_o_valid;

    assign s1_adv      = !r_o_valid || o_rsp.ready;
    assign s1_fire     = r_s1_valid && s1_adv;
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign acc         = i_req.valid && i_req.ready;
    assign is_read     = (i_req.cmd == CMD_READ);
    assign step        = acc && !is_read;

    hrlc_parse u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_byte (i_req.data_byte),
        .i_eol  (i_req.end_of_line),
        .o_cls  (line_cls)
    );

    always_comb begin
        idx_off = i_req.counter_index - IDX_W'(URI_IDX_BASE);
        if (i_req.counter_index < IDX_W'(URI_IDX_BASE)) begin
            rsel = RSEL_METH;
        end else if (i_req.counter_index <= IDX_W'(READ_IDX_LAST)) begin
            rsel = RSEL_URI;
        end else begin
            rsel = RSEL_NONE;
        end
        m_addr0 = is_read ? i_req.counter_index[M_AW-1:0] : M_AW'(line_cls.method);
        u_addr0 = is_read ? idx_off[U_AW-1:0] : U_AW'(line_cls.uri);
        // Hold the stalled entry's address so its read is repeated
        m_raddr = acc ? m_addr0 : r_s1_m;
        u_raddr = acc ? u_addr0 : r_s1_u;
    end

    hrlc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_METH_CLS)) u_meth_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(r_s1_m),
        .i_wdata(m_new),
        .i_raddr(m_raddr),
        .o_rdata(m_q)
    );

    hrlc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_URI_CLS)) u_uri_ram (
        .i_clk  (i_clk),
        .i_we   (u_we),
        .i_waddr(r_s1_u),
        .i_wdata(u_new),
        .i_raddr(u_raddr),
        .o_rdata(u_q)
    );

    always_comb begin
        if (r_fw_m_vld && (r_fw_m_addr == r_s1_m)) begin
            m_old = r_fw_m_data;
        end else begin
            m_old = r_m_vld[r_s1_m] ? m_q : '0;
        end
        if (r_fw_u_vld && (r_fw_u_addr == r_s1_u)) begin
            u_old = r_fw_u_data;
        end else begin
            u_old = r_u_vld[r_s1_u] ? u_q : '0;
        end
        m_new = (m_old == '1) ? m_old : m_old + 1'b1;
        u_new = (u_old == '1) ? u_old : u_old + 1'b1;
        m_we  = s1_fire && (r_s1_kind == KIND_LINE);
        u_we  = m_we;
        ext_m_new = {{OUT_W{1'b0}}, m_new};
        ext_u_new = {{OUT_W{1'b0}}, u_new};
        ext_m_old = {{OUT_W{1'b0}}, m_old};
        ext_u_old = {{OUT_W{1'b0}}, u_old};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_fw_m_vld <= 1'b0;
            r_fw_u_vld <= 1'b0;
            r_m_vld    <= '0;
            r_u_vld    <= '0;
        end else begin
            if (acc && (is_read || i_req.end_of_line)) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            r_fw_m_vld <= m_we;
            r_fw_u_vld <= u_we;
            if (m_we) r_m_vld[r_s1_m] <= 1'b1;
            if (u_we) r_u_vld[r_s1_u] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_kind  <= is_read ? KIND_READ : KIND_LINE;
            r_s1_sel   <= rsel;
            r_s1_m     <= m_addr0;
            r_s1_u     <= u_addr0;
            r_s1_proto <= line_cls.proto;
        end
        r_fw_m_addr <= r_s1_m;
        r_fw_u_addr <= r_s1_u;
        r_fw_m_data <= m_new;
        r_fw_u_data <= u_new;
        if (s1_fire) begin
            o_rsp.kind <= r_s1_kind;
            if (r_s1_kind == KIND_LINE) begin
                o_rsp.method_class   <= CLS_W'(r_s1_m);
                o_rsp.uri_class      <= CLS_W'(r_s1_u);
                o_rsp.protocol_known <= r_s1_proto;
                o_rsp.method_count   <= ext_m_new[OUT_W-1:0];
                o_rsp.uri_count      <= ext_u_new[OUT_W-1:0];
                o_rsp.read_value     <= '0;
            end else begin
                o_rsp.method_class   <= '0;
                o_rsp.uri_class      <= '0;
                o_rsp.protocol_known <= 1'b0;
                o_rsp.method_count   <= '0;
                o_rsp.uri_count      <= '0;
                unique case (r_s1_sel)
                    RSEL_METH: o_rsp.read_value <= ext_m_old[OUT_W-1:0];
                    RSEL_URI:  o_rsp.read_value <= ext_u_old[OUT_W-1:0];
                    default:   o_rsp.read_value <= '0;
                endcase
            end
        end
    end

    assign o_rsp.valid = r_o_valid;
endmodule
`default_nettype wire

>>> tb/sv/http_request_line_classifier_stats_test.sv
// Self-checking testbench for the request line classifier: stimulus, prediction and scoring.
`timescale 1ns / 1ps
module http_request_line_classifier_stats_test;
    import hrlc_pkg::*;

    localparam int  IDLE_MAX     = 7;
    localparam int  RST_CYCLES   = 10;
    localparam int  HOLD_CYCLES  = 200;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  ITEMS        = 1250;
    localparam int  NUM_PHASES   = 6;
    localparam int  MAX_REPORTS  = 10;
    localparam int  IDX_TOP      = (1 << IDX_W) - 1;
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    typedef struct {
        logic             kind;
        logic [CLS_W-1:0] method_class;
        logic [CLS_W-1:0] uri_class;
        logic             protocol_known;
        logic [OUT_W-1:0] method_count;
        logic [OUT_W-1:0] uri_count;
        logic [OUT_W-1:0] read_value;
    } t_cls_result;

    class line_scoreboard;
        t_tok              tok;
        bit                skipping;
        logic [POS_W-1:0]  pos;
        logic [MASK_W-1:0] mask;
        logic [CLS_W-1:0]  lat_method;
        logic [CLS_W-1:0]  lat_uri;
        logic              lat_proto;
        logic [OUT_W-1:0]  method_tally [NUM_METH_CLS];
        logic [OUT_W-1:0]  uri_tally [NUM_URI_CLS];
        string             method_words [4];
        string             uri_words [5];
        string             proto_word;
        t_cls_result       awaited [$];
        int                mismatches;
        int                lines_seen;
        int                reads_seen;

        function new();
            method_words = '{"GET", "POST", "PUT", "DELETE"};
            uri_words    = '{"/", "/order", "/product", "/basket", "/help"};
            proto_word   = "HTTP/1.1";
            foreach (method_tally[i]) method_tally[i] = '0;
            foreach (uri_tally[i]) uri_tally[i] = '0;
            mismatches = 0;
            lines_seen = 0;
            reads_seen = 0;
            start_line();
        endfunction

        function void start_token();
            skipping = 1'b1;
            pos      = '0;
            mask     = '1;
        endfunction

        function void start_line();
            tok        = TOK_METHOD;
            lat_method = METH_UNKNOWN;
            lat_uri    = URI_UNKNOWN;
            lat_proto  = 1'b0;
            start_token();
        endfunction

        function bit agrees(string w, logic [7:0] b);
            logic [7:0] c;
            if (pos >= w.len()) return 1'b0;
            c = w[pos];
            return c == b;
        endfunction

        // Drop every keyword that no longer agrees with the token so far.
        function void take_char(logic [7:0] b);
            case (tok)
                TOK_METHOD: begin
                    for (int i = 0; i < 4; i++) if (!agrees(method_words[i], b)) mask[i] = 1'b0;
                end
                TOK_URI: begin
                    for (int i = 0; i < 5; i++) if (!agrees(uri_words[i], b)) mask[i] = 1'b0;
                end
                TOK_PROTO: begin
                    if (!agrees(proto_word, b)) mask[0] = 1'b0;
                end
                default: ;
            endcase
            if (pos != POS_MAX) pos = pos + 1'b1;
        endfunction

        // Latch the class of the token just closed; the lowest surviving keyword wins.
        function void close_token();
            case (tok)
                TOK_METHOD: begin
                    lat_method = METH_UNKNOWN;
                    for (int i = 3; i >= 0; i--)
                        if (mask[i] && method_words[i].len() == pos) lat_method = CLS_W'(i);
                end
                TOK_URI: begin
                    lat_uri = URI_UNKNOWN;
                    for (int i = 4; i >= 0; i--)
                        if (mask[i] && uri_words[i].len() == pos) lat_uri = CLS_W'(i);
                end
                TOK_PROTO: lat_proto = mask[0] && (proto_word.len() == pos);
                default: ;
            endcase
        endfunction

        function logic [OUT_W-1:0] bumped(logic [OUT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void note_input(logic cmd, logic [7:0] b, logic eol, logic [IDX_W-1:0] idx);
            t_cls_result r;
            r = '{default: '0};
            if (cmd == CMD_READ) begin
                r.kind = KIND_READ;
                if (idx < URI_IDX_BASE) r.read_value = method_tally[idx];
                else if (idx <= READ_IDX_LAST) r.read_value = uri_tally[idx - URI_IDX_BASE];
                awaited.push_back(r);
                reads_seen++;
                return;
            end
            if (tok != TOK_DONE) begin
                if (b == CHAR_SPACE) begin
                    if (!skipping) begin
                        close_token();
                        tok = t_tok'(tok + 1);
                        start_token();
                    end
                end else begin
                    skipping = 1'b0;
                    take_char(b);
                end
            end
            if (!eol) return;
            if (tok != TOK_DONE) close_token();
            method_tally[lat_method] = bumped(method_tally[lat_method]);
            uri_tally[lat_uri]       = bumped(uri_tally[lat_uri]);
            r.kind           = KIND_LINE;
            r.method_class   = lat_method;
            r.uri_class      = lat_uri;
            r.protocol_known = lat_proto;
            r.method_count   = method_tally[lat_method];
            r.uri_count      = uri_tally[lat_uri];
            awaited.push_back(r);
            lines_seen++;
            start_line();
        endfunction

        function void flag(string what, t_cls_result want, t_cls_result got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t %s: exp kind=%0d m=%0d u=%0d p=%0d mc=%0d uc=%0d rv=%0d",
                         $time, what, want.kind, want.method_class, want.uri_class,
                         want.protocol_known, want.method_count, want.uri_count,
                         want.read_value);
                $display("%0t %s: got kind=%0d m=%0d u=%0d p=%0d mc=%0d uc=%0d rv=%0d",
                         $time, what, got.kind, got.method_class, got.uri_class,
                         got.protocol_known, got.method_count, got.uri_count,
                         got.read_value);
            end
        endfunction

        function void check_result(t_cls_result got);
            t_cls_result want;
            bit          same;
            if (awaited.size() == 0) begin
                want = '{default: '0};
                flag("unexpected result", want, got);
                return;
            end
            want = awaited.pop_front();
            same = (got.kind === want.kind) && (got.method_class === want.method_class) &&
                   (got.uri_class === want.uri_class) &&
                   (got.protocol_known === want.protocol_known) &&
                   (got.method_count === want.method_count) &&
                   (got.uri_count === want.uri_count) && (got.read_value === want.read_value);
            if (!same) flag("result mismatch", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hrlc_req_if req_if ();
    hrlc_rsp_if rsp_if ();

    http_request_line_classifier_stats u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    line_scoreboard sb;
    bit             src_idle;
    bit             snk_idle;
    bit             mix_reads;
    bit             hold_req;
    int             items_sent;
    logic [7:0]     line_buf [$];

    task automatic send_item(logic cmd, logic [7:0] b, logic eol, logic [IDX_W-1:0] idx);
        int gap;
        gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.cmd           <= cmd;
        req_if.data_byte     <= b;
        req_if.end_of_line   <= eol;
        req_if.counter_index <= idx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_input(cmd, b, eol, idx);
        items_sent++;
    endtask

    task automatic send_read(logic [IDX_W-1:0] idx);
        send_item(CMD_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    // Stream the line buffer, flagging the last byte; with mix_reads set, slip in counter reads mid-line.
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            if (mix_reads && $urandom_range(0, 9) == 0)
                send_read(IDX_W'($urandom_range(0, IDX_TOP)));
            send_item(CMD_BYTE, line_buf[i], i == line_buf.size() - 1,
                      IDX_W'($urandom_range(0, IDX_TOP)));
        end
    endtask

    // Hold the sender until every awaited result is back, then let the pipeline settle.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void put_spaces(int lo, int hi);
        repeat ($urandom_range(lo, hi)) line_buf.push_back(CHAR_SPACE);
    endfunction

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_SPACE);
        return c;
    endfunction

    // Mostly the keyword itself, otherwise a prefix, an overrun, a near miss or junk.
    function automatic void put_token(string w);
        int k;
        case ($urandom_range(0, 9))
            6: begin
                k = $urandom_range(0, w.len() - 1);
                for (int i = 0; i < k; i++) line_buf.push_back(w[i]);
            end
            7: begin
                put_text(w);
                line_buf.push_back(rand_char());
            end
            8: begin
                k = $urandom_range(0, w.len() - 1);
                for (int i = 0; i < w.len(); i++)
                    line_buf.push_back((i == k) ? rand_char() : 8'(w[i]));
            end
            9: begin
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
                repeat (k) line_buf.push_back(rand_char());
            end
            default: put_text(w);
        endcase
    endfunction

    function automatic void build_line();
        int shape;
        line_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        shape = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) put_spaces(1, 3);
        put_token(sb.method_words[$urandom_range(0, 3)]);
        if (shape >= 1) begin
            put_spaces(1, 3);
            put_token(sb.uri_words[$urandom_range(0, 4)]);
        end
        if (shape >= 2) begin
            put_spaces(1, 3);
            put_token(sb.proto_word);
        end
        if (shape == 9) begin
            repeat ($urandom_range(1, 2)) begin
                put_spaces(1, 2);
                repeat ($urandom_range(1, 4)) line_buf.push_back(rand_char());
            end
        end
        if ($urandom_range(0, 3) == 0) put_spaces(1, 2);
        if (line_buf.size() == 0) line_buf.push_back(CHAR_SPACE);
    endfunction

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // Response side: random back-pressure, plus one long hold-off on request.
    initial begin
        t_cls_result got;
        int          gap;
        rsp_if.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = snk_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (gap != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            got.kind           = rsp_if.kind;
            got.method_class   = rsp_if.method_class;
            got.uri_class      = rsp_if.uri_class;
            got.protocol_known = rsp_if.protocol_known;
            got.method_count   = rsp_if.method_count;
            got.uri_count      = rsp_if.uri_count;
            got.read_value     = rsp_if.read_value;
            sb.check_result(got);
        end
    end

    initial begin
        int budget;
        sb                   = new();
        items_sent           = 0;
        hold_req             = 1'b0;
        src_idle             = 1'b1;
        snk_idle             = 1'b1;
        mix_reads            = 1'b0;
        req_if.valid         = 1'b0;
        req_if.cmd           = CMD_BYTE;
        req_if.data_byte     = '0;
        req_if.end_of_line   = 1'b0;
        req_if.counter_index = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fresh counters, out-of-range read, a clean line, odd bytes, a blank line.
        send_read('0);
        send_read(IDX_W'(IDX_TOP));
        send_read(IDX_W'(URI_IDX_BASE));
        line_buf.delete();
        put_text("GET / HTTP/1.1");
        send_line();
        line_buf.delete();
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        send_line();
        line_buf.delete();
        line_buf.push_back(CHAR_SPACE);
        send_line();
        send_read('0);
        send_read(IDX_W'(METH_UNKNOWN));
        send_read(IDX_W'(READ_IDX_LAST));
        drain();

        mix_reads = 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: begin src_idle = 1'b0; snk_idle = 1'b0; end
                2: begin src_idle = 1'b1; snk_idle = 1'b0; end
                3: begin src_idle = 1'b0; snk_idle = 1'b1; hold_req = 1'b1; end
                5: begin src_idle = 1'($urandom); snk_idle = 1'($urandom); end
                default: begin src_idle = 1'b1; snk_idle = 1'b1; end
            endcase
            budget = items_sent + ITEMS / NUM_PHASES;
            while (items_sent < budget) begin
                build_line();
                send_line();
            end
            drain();
        end

        if (sb.awaited.size() != 0) sb.mismatches++;
        $display("Run covered %0d transfers: %0d request lines classified, %0d counter reads.",
                 items_sent, sb.lines_seen, sb.reads_seen);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
